// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  `ASSERT_AT(lbl, clk, rst, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  `ASSERT_AT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

// ===== hdl/prac_pkg.sv =====
// Shared types, constants and helpers of the row activation tracker.
package prac_pkg;

  localparam int TOTAL_ROWS_DEF       = 65536;
  localparam int ROWS_PER_REFRESH_DEF = 8;
  localparam int REFRESH_GROUPS_DEF   = 8192;
  localparam int COUNTER_WIDTH_DEF    = 16;

  localparam int MODE_W     = 2;
  localparam int ROW_W      = 16;
  localparam int OPEN_W     = 24;
  localparam int TH_W       = 16;
  localparam int RPM_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int INC_W      = 5;

  localparam int CYCLES_PER_NS = 4;
  localparam int TON_SHORT_NS  = 180;
  localparam int TON_LONG_NS   = 360;
  localparam int CREDIT_SHORT  = 1;
  localparam int CREDIT_MID    = 2;
  localparam int CREDIT_LONG   = 20;
  localparam int ACT_CREDIT    = 1;

  localparam int NB_MIN_OFFSET = -2;
  localparam int NB_COUNT      = 4;
  localparam int NB_IDX_W      = 2;

  localparam logic [TH_W-1:0]  ALERT_TH_RST = TH_W'(64);
  localparam logic [TH_W-1:0]  ENTRY_TH_RST = TH_W'(32);
  localparam logic [RPM_W-1:0] RPM_RST      = RPM_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_TH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_TH   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_EN_TRACKER = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_EN_CREDIT  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_CLR_ON_REF = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_REF_PER_MIT = CFG_IDX_W'(5);

  typedef enum logic [MODE_W-1:0] {
    MODE_ACT,
    MODE_PRE,
    MODE_REF,
    MODE_ALERT
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_TRK,
    ST_REF_CLR,
    ST_REF_WAIT,
    ST_MIT_ZERO,
    ST_NB_RD,
    ST_NB_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic zero;
  } rem_stat_t;

  // Precharge credit from open time.
  function automatic logic [INC_W-1:0] open_credit(input logic [OPEN_W-1:0] oc);
    logic [OPEN_W-1:0] ton;
    logic [INC_W-1:0]  inc;
    ton = oc >> $clog2(CYCLES_PER_NS);
    priority if (ton <= OPEN_W'(TON_SHORT_NS)) begin
      inc = INC_W'(CREDIT_SHORT);
    end else if (ton <= OPEN_W'(TON_LONG_NS)) begin
      inc = INC_W'(CREDIT_MID);
    end else begin
      inc = INC_W'(CREDIT_LONG);
    end
    return inc;
  endfunction

  // Neighbor distance by step: -2, -1, +1, +2.
  function automatic logic signed [2:0] nb_offset(input logic [NB_IDX_W-1:0] idx);
    logic signed [2:0] off;
    unique case (idx)
      2'd0:    off = 3'(NB_MIN_OFFSET);
      2'd1:    off = 3'(NB_MIN_OFFSET + 1);
      2'd2:    off = 3'(-(NB_MIN_OFFSET + 1));
      default: off = 3'(-NB_MIN_OFFSET);
    endcase
    return off;
  endfunction

endpackage

// ===== hdl/prac_if.sv =====
// Valid/ready channel interfaces for tracker events and results.
interface prac_in_if;
  logic                          valid;
  logic                          ready;
  logic [prac_pkg::MODE_W-1:0]   mode;
  logic [prac_pkg::ROW_W-1:0]    row;
  logic [prac_pkg::OPEN_W-1:0]   open_cycles;

  modport source (output valid, mode, row, open_cycles, input ready);
  modport sink (input valid, mode, row, open_cycles, output ready);
endinterface

interface prac_out_if;
  logic                        valid;
  logic                        ready;
  logic                        alert;
  logic                        mitigated;
  logic [prac_pkg::ROW_W-1:0]  mit_row;
  logic [prac_pkg::ROW_W-1:0]  row_count;
  logic                        tracked_valid;
  logic [prac_pkg::ROW_W-1:0]  tracked_row;

  modport source (output valid, alert, mitigated, mit_row, row_count, tracked_valid,
                  tracked_row, input ready);
  modport sink (input valid, alert, mitigated, mit_row, row_count, tracked_valid,
                tracked_row, output ready);
endinterface

// ===== hdl/prac_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
module prac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/prac_rem.sv =====
// Bit-serial remainder unit: one quotient bit per cycle.
`include "assert_macros.svh"

module prac_rem #(
  parameter int NW = 13,
  parameter int DW = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NW-1:0]       num,
  input  logic [DW-1:0]       den,
  output prac_pkg::rem_stat_t stat
);

  localparam int KW = $clog2(NW + 1);

  logic [KW-1:0] cnt;
  logic [NW-1:0] num_sh;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem, num_sh[NW-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= KW'(NW);
    end else if (cnt != '0) begin
      cnt <= cnt - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      rem    <= '0;
    end else if (cnt != '0) begin
      num_sh <= num_sh << 1;
      rem    <= (trial >= {1'b0, den}) ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.zero = (rem == '0);

  `ASSERT_NEXT(a_rem_busy_after_start, clk, rst, start, stat.busy, "remainder idle after start")

endmodule

// ===== hdl/prac_rowhammer_tracker_top.sv =====
// Top level of the per-row activation counter and single-entry mitigation tracker.
// After reset the counter memory is swept to zero, one row a cycle; items wait,
// configuration writes are taken. Then one item is handled at a time, each counter
// update a read-modify-write on the single counter memory. An activate or precharge
// reads its counter when accepted and writes it back, and an activate may then compare
// it with the tracked row's count; an alert service mitigates when a row is tracked (zero
// the victim, then read and write up to four neighbors); a refresh clears its group of
// ROWS_PER_REFRESH rows when clear on refresh is set, waits for the bit-serial group
// remainder, which runs alongside, and may then mitigate as well. A finished result sits
// in an output register, so the next item is taken while the result waits; the result
// step stretches only while an earlier result is still not accepted.
`include "assert_macros.svh"

module prac_rowhammer_tracker_top #(
  parameter int TOTAL_ROWS       = prac_pkg::TOTAL_ROWS_DEF,
  parameter int ROWS_PER_REFRESH = prac_pkg::ROWS_PER_REFRESH_DEF,
  parameter int REFRESH_GROUPS   = prac_pkg::REFRESH_GROUPS_DEF,
  parameter int COUNTER_WIDTH    = prac_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [prac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prac_pkg::CFG_DATA_W-1:0]   cfg_data,
  prac_in_if.sink                           in_ch,
  prac_out_if.source                        out_ch
);

  localparam int ROW_W = prac_pkg::ROW_W;
  localparam int AW    = (TOTAL_ROWS > 1) ? $clog2(TOTAL_ROWS) : 1;
  localparam int GW    = (REFRESH_GROUPS > 1) ? $clog2(REFRESH_GROUPS) : 1;
  localparam int CIW   = (ROWS_PER_REFRESH > 1) ? $clog2(ROWS_PER_REFRESH) : 1;
  localparam int RFW   = GW + CIW;
  localparam int RLW   = (RFW > AW + 1) ? RFW : AW + 1;
  localparam int QW    = (ROW_W > AW + 1) ? ROW_W : AW + 1;
  localparam int XW    = (ROW_W + 1 > AW + 1) ? ROW_W + 1 : AW + 1;
  localparam int CW    = COUNTER_WIDTH;
  localparam int SW    = CW + prac_pkg::INC_W;
  localparam int MW    = (CW > prac_pkg::TH_W) ? CW : prac_pkg::TH_W;
  localparam int IW    = prac_pkg::INC_W;

  prac_pkg::state_t state, state_next;

  logic [prac_pkg::TH_W-1:0]  alert_th;
  logic [prac_pkg::TH_W-1:0]  entry_th;
  logic                       en_trk;
  logic                       en_credit;
  logic                       clr_on_ref;
  logic [prac_pkg::RPM_W-1:0] rpm;

  logic             tracker_valid;
  logic [ROW_W-1:0] tracker_row;
  logic [GW-1:0]    refresh_group;
  logic [GW-1:0]    grp_next;
  logic [AW-1:0]    clr_ptr;

  prac_pkg::mode_t  req_mode;
  logic [ROW_W-1:0] req_row;
  logic [IW-1:0]    req_inc;
  logic [CW-1:0]    cnt;
  logic             res_alert;
  logic             res_mit;
  logic [ROW_W-1:0] victim;
  logic [RFW-1:0]   ref_base;
  logic [CIW-1:0]   ref_idx;
  logic [prac_pkg::NB_IDX_W-1:0] nb_idx;

  logic             out_valid_r;
  logic             out_alert;
  logic             out_mitigated;
  logic [ROW_W-1:0] out_victim;
  logic [ROW_W-1:0] out_count;
  logic             out_tracked_valid;
  logic [ROW_W-1:0] out_tracked_row;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [CW-1:0] ram_rdata;

  logic                 rem_start;
  prac_pkg::rem_stat_t  rem_stat;

  logic            in_ready;
  logic            in_acc;
  prac_pkg::mode_t in_mode;
  logic            in_row_ok;
  logic [IW-1:0]   upd_amt;
  logic [SW-1:0]   upd_sum;
  logic [CW-1:0]   upd_val;
  logic            upd_alert;
  logic            upd_enter;
  logic            trk_far;
  logic            trk_win;
  logic [RFW-1:0]  ref_row;
  logic            ref_ok;
  logic            ref_last;
  logic            vic_ok;
  logic signed [XW:0] nb_s;
  logic            nb_ok;
  logic            nb_last;
  logic [AW-1:0]   nb_addr;
  logic            mit_req;
  logic            out_free;

  prac_ram #(
    .WIDTH (CW),
    .DEPTH (TOTAL_ROWS)
  ) u_counters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  prac_rem #(
    .NW (GW),
    .DW (prac_pkg::RPM_W)
  ) u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (rem_start),
    .num   (grp_next),
    .den   (rpm),
    .stat  (rem_stat)
  );

  assign in_ready  = (state == prac_pkg::ST_IDLE);
  assign in_acc    = in_ch.valid && in_ready;
  assign in_mode   = prac_pkg::mode_t'(in_ch.mode);
  assign in_row_ok = QW'(in_ch.row) < QW'(TOTAL_ROWS);
  assign grp_next  = (refresh_group == GW'(REFRESH_GROUPS - 1)) ? '0 : refresh_group + GW'(1);

  assign upd_amt   = (state == prac_pkg::ST_NB_WR) ? IW'(1) : req_inc;
  assign upd_sum   = SW'(ram_rdata) + SW'(upd_amt);
  assign upd_val   = (|upd_sum[SW-1:CW]) ? '1 : upd_sum[CW-1:0];
  assign upd_alert = en_trk && (req_mode == prac_pkg::MODE_ACT || en_credit) &&
                     (MW'(upd_val) >= MW'(alert_th));
  assign upd_enter = (req_mode == prac_pkg::MODE_ACT) && en_trk &&
                     (MW'(upd_val) > MW'(entry_th)) &&
                     !(tracker_valid && tracker_row == req_row);
  assign trk_far   = !tracker_valid || (QW'(tracker_row) >= QW'(TOTAL_ROWS));
  assign trk_win   = cnt > ram_rdata;

  assign ref_row  = ref_base + RFW'(ref_idx);
  assign ref_ok   = RLW'(ref_row) < RLW'(TOTAL_ROWS);
  assign ref_last = (ref_idx == CIW'(ROWS_PER_REFRESH - 1));

  assign vic_ok  = QW'(tracker_row) < QW'(TOTAL_ROWS);
  assign nb_s    = $signed({{(XW + 1 - ROW_W){1'b0}}, victim}) +
                   (XW + 1)'(prac_pkg::nb_offset(nb_idx));
  assign nb_ok   = !nb_s[XW] && (nb_s[XW-1:0] < XW'(TOTAL_ROWS));
  assign nb_addr = AW'(nb_s[XW-1:0]);
  assign nb_last = (nb_idx == prac_pkg::NB_IDX_W'(prac_pkg::NB_COUNT - 1));

  assign mit_req  = (rpm != '0) && rem_stat.zero && en_trk && tracker_valid;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      prac_pkg::ST_CLEAR: begin
        if (clr_ptr == AW'(TOTAL_ROWS - 1)) state_next = prac_pkg::ST_IDLE;
      end
      prac_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            prac_pkg::MODE_ACT, prac_pkg::MODE_PRE: begin
              state_next = in_row_ok ? prac_pkg::ST_UPD : prac_pkg::ST_DONE;
            end
            prac_pkg::MODE_REF: begin
              state_next = clr_on_ref ? prac_pkg::ST_REF_CLR : prac_pkg::ST_REF_WAIT;
            end
            prac_pkg::MODE_ALERT: begin
              state_next = (en_trk && tracker_valid) ? prac_pkg::ST_MIT_ZERO
                                                     : prac_pkg::ST_DONE;
            end
          endcase
        end
      end
      prac_pkg::ST_UPD: begin
        state_next = (upd_enter && !trk_far) ? prac_pkg::ST_TRK : prac_pkg::ST_DONE;
      end
      prac_pkg::ST_TRK: state_next = prac_pkg::ST_DONE;
      prac_pkg::ST_REF_CLR: begin
        if (ref_last) state_next = prac_pkg::ST_REF_WAIT;
      end
      prac_pkg::ST_REF_WAIT: begin
        if (!rem_stat.busy) state_next = mit_req ? prac_pkg::ST_MIT_ZERO : prac_pkg::ST_DONE;
      end
      prac_pkg::ST_MIT_ZERO: state_next = prac_pkg::ST_NB_RD;
      prac_pkg::ST_NB_RD: begin
        if (nb_ok) begin
          state_next = prac_pkg::ST_NB_WR;
        end else if (nb_last) begin
          state_next = prac_pkg::ST_DONE;
        end
      end
      prac_pkg::ST_NB_WR: state_next = nb_last ? prac_pkg::ST_DONE : prac_pkg::ST_NB_RD;
      prac_pkg::ST_DONE: begin
        if (out_free) state_next = prac_pkg::ST_IDLE;
      end
      default: state_next = prac_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    rem_start = 1'b0;
    unique case (state)
      prac_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ptr;
      end
      prac_pkg::ST_IDLE: begin
        if (in_acc && (in_mode == prac_pkg::MODE_ACT || in_mode == prac_pkg::MODE_PRE) &&
            in_row_ok) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(in_ch.row);
        end
        rem_start = in_acc && (in_mode == prac_pkg::MODE_REF);
      end
      prac_pkg::ST_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(req_row);
        ram_wdata = upd_val;
        // tracked row's count for the insertion compare
        if (upd_enter && !trk_far) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(tracker_row);
        end
      end
      prac_pkg::ST_REF_CLR: begin
        ram_we    = ref_ok;
        ram_waddr = AW'(ref_row);
      end
      prac_pkg::ST_MIT_ZERO: begin
        ram_we    = vic_ok;
        ram_waddr = AW'(tracker_row);
      end
      prac_pkg::ST_NB_RD: begin
        ram_re    = nb_ok;
        ram_raddr = nb_addr;
      end
      prac_pkg::ST_NB_WR: begin
        ram_we    = 1'b1;
        ram_waddr = nb_addr;
        ram_wdata = upd_val;
      end
      prac_pkg::ST_TRK, prac_pkg::ST_REF_WAIT, prac_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= prac_pkg::ST_CLEAR;
      clr_ptr       <= '0;
      alert_th      <= prac_pkg::ALERT_TH_RST;
      entry_th      <= prac_pkg::ENTRY_TH_RST;
      en_trk        <= 1'b1;
      en_credit     <= 1'b1;
      clr_on_ref    <= 1'b1;
      rpm           <= prac_pkg::RPM_RST;
      tracker_valid <= 1'b0;
      tracker_row   <= '0;
      refresh_group <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          prac_pkg::CFG_ALERT_TH:    alert_th   <= cfg_data[prac_pkg::TH_W-1:0];
          prac_pkg::CFG_ENTRY_TH:    entry_th   <= cfg_data[prac_pkg::TH_W-1:0];
          prac_pkg::CFG_EN_TRACKER:  en_trk     <= cfg_data[0];
          prac_pkg::CFG_EN_CREDIT:   en_credit  <= cfg_data[0];
          prac_pkg::CFG_CLR_ON_REF:  clr_on_ref <= cfg_data[0];
          prac_pkg::CFG_REF_PER_MIT: rpm        <= cfg_data[prac_pkg::RPM_W-1:0];
          default: begin
          end
        endcase
      end
      if (state == prac_pkg::ST_CLEAR) clr_ptr <= clr_ptr + AW'(1);
      if (in_acc && in_mode == prac_pkg::MODE_REF) refresh_group <= grp_next;
      if (state == prac_pkg::ST_UPD && upd_enter && trk_far) begin
        tracker_valid <= 1'b1;
        tracker_row   <= req_row;
      end
      if (state == prac_pkg::ST_TRK && trk_win) begin
        tracker_valid <= 1'b1;
        tracker_row   <= req_row;
      end
      if (state == prac_pkg::ST_MIT_ZERO) begin
        tracker_valid <= 1'b0;
        tracker_row   <= '0;
      end
      if (state == prac_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_mode  <= in_mode;
      req_row   <= in_ch.row;
      req_inc   <= (in_mode == prac_pkg::MODE_ACT) ? IW'(prac_pkg::ACT_CREDIT) :
                   en_credit ? prac_pkg::open_credit(in_ch.open_cycles) : '0;
      cnt       <= '0;
      res_alert <= 1'b0;
      res_mit   <= 1'b0;
      victim    <= '0;
      ref_idx   <= '0;
      ref_base  <= RFW'(refresh_group) * RFW'(ROWS_PER_REFRESH);
    end
    if (state == prac_pkg::ST_UPD) begin
      cnt       <= upd_val;
      res_alert <= upd_alert;
    end
    if (state == prac_pkg::ST_REF_CLR) ref_idx <= ref_idx + CIW'(1);
    if (state == prac_pkg::ST_MIT_ZERO) begin
      victim  <= tracker_row;
      res_mit <= 1'b1;
      nb_idx  <= '0;
    end
    if ((state == prac_pkg::ST_NB_RD && !nb_ok) || state == prac_pkg::ST_NB_WR) begin
      nb_idx <= nb_idx + prac_pkg::NB_IDX_W'(1);
    end
    if (state == prac_pkg::ST_DONE && out_free) begin
      out_alert         <= res_alert;
      out_mitigated     <= res_mit;
      out_victim        <= victim;
      out_count         <= ROW_W'(cnt);
      out_tracked_valid <= tracker_valid;
      out_tracked_row   <= tracker_valid ? tracker_row : '0;
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.alert         = out_alert;
  assign out_ch.mitigated     = out_mitigated;
  assign out_ch.mit_row       = out_victim;
  assign out_ch.row_count     = out_count;
  assign out_ch.tracked_valid = out_tracked_valid;
  assign out_ch.tracked_row   = out_tracked_row;

  `ASSERT_IMP(a_no_same_row_rw, clk, rst, ram_we && ram_re, ram_waddr != ram_raddr, "read and write hit one counter")
  `ASSERT_NEXT(a_read_consumed, clk, rst, ram_re, state == prac_pkg::ST_UPD || state == prac_pkg::ST_TRK || state == prac_pkg::ST_NB_WR, "read data not consumed")
  `ASSERT_NEXT(a_one_item, clk, rst, in_acc, !in_ready, "second item taken while busy")
  `ASSERT_IMP(a_mit_empties, clk, rst, out_valid_r && out_mitigated, !out_tracked_valid, "tracker not emptied by mitigation")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the per-row activation counter and mitigation tracker.
module tb_top;
  import prac_pkg::*;

  localparam int ROWS       = TOTAL_ROWS_DEF;
  localparam int PER_REF    = ROWS_PER_REFRESH_DEF;
  localparam int GROUPS     = REFRESH_GROUPS_DEF;
  localparam int CNT_MAX    = (1 << COUNTER_WIDTH_DEF) - 1;
  localparam int DRAIN      = 32;
  localparam int QUIET_MAX  = 300000;
  localparam int IDLE_PCT   = 24;
  localparam int PHASE_LEN  = 225;
  localparam int HEAVY_LEN  = 60;

  typedef struct packed {
    logic             alert;
    logic             mitigated;
    logic [ROW_W-1:0] mit_row;
    logic [ROW_W-1:0] row_count;
    logic             tracked_valid;
    logic [ROW_W-1:0] tracked_row;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  prac_in_if  in_ch();
  prac_out_if out_ch();

  prac_rowhammer_tracker_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the counter store, tracker and registers.
  bit [COUNTER_WIDTH_DEF-1:0] row_cnt [ROWS];
  bit               trk_valid;
  bit [ROW_W-1:0]   trk_row;
  int               ref_group;
  bit [TH_W-1:0]    th_alert;
  bit [TH_W-1:0]    th_entry;
  bit               en_trk;
  bit               en_credit;
  bit               clr_ref;
  int               rpm;

  outcome_t         pending_outcomes[$];
  int               mismatches = 0;
  int               quiet;
  bit               no_idle;
  logic [ROW_W-1:0] hot_rows [8];

  function automatic void bump_count(int r, int amount);
    int c;
    if (r < 0 || r >= ROWS) return;
    c = row_cnt[r] + amount;
    row_cnt[r] = (c > CNT_MAX) ? CNT_MAX[COUNTER_WIDTH_DEF-1:0] : c[COUNTER_WIDTH_DEF-1:0];
  endfunction

  function automatic bit mitigate_tracked(output logic [ROW_W-1:0] victim);
    int v;
    victim = '0;
    if (!trk_valid) return 1'b0;
    v = trk_row;
    row_cnt[v] = '0;
    bump_count(v - 2, 1);
    bump_count(v - 1, 1);
    bump_count(v + 1, 1);
    bump_count(v + 2, 1);
    trk_valid = 1'b0;
    trk_row = '0;
    victim = v[ROW_W-1:0];
    return 1'b1;
  endfunction

  function automatic void track_row(logic [ROW_W-1:0] r);
    if (row_cnt[r] <= th_entry) return;
    if (trk_valid && trk_row == r) return;
    if (!trk_valid || row_cnt[r] > row_cnt[trk_row]) begin
      trk_valid = 1'b1;
      trk_row = r;
    end
  endfunction

  function automatic outcome_t predict_event(mode_t m, logic [ROW_W-1:0] r,
                                             logic [OPEN_W-1:0] oc);
    outcome_t o;
    int ton;
    int credit;
    int g;
    o = '0;
    case (m)
      MODE_ACT: begin
        bump_count(r, ACT_CREDIT);
        if (en_trk) begin
          o.alert = row_cnt[r] >= th_alert;
          track_row(r);
        end
        o.row_count = row_cnt[r];
      end
      MODE_PRE: begin
        if (en_credit) begin
          ton = oc / CYCLES_PER_NS;
          if (ton <= TON_SHORT_NS) credit = CREDIT_SHORT;
          else if (ton <= TON_LONG_NS) credit = CREDIT_MID;
          else credit = CREDIT_LONG;
          bump_count(r, credit);
          if (en_trk) o.alert = row_cnt[r] >= th_alert;
        end
        o.row_count = row_cnt[r];
      end
      MODE_REF: begin
        if (clr_ref) begin
          for (g = 0; g < PER_REF; g++) begin
            if (ref_group * PER_REF + g < ROWS) row_cnt[ref_group * PER_REF + g] = '0;
          end
        end
        ref_group = (ref_group + 1) % GROUPS;
        if (rpm != 0 && ref_group % rpm == 0 && en_trk)
          o.mitigated = mitigate_tracked(o.mit_row);
      end
      default: begin
        if (en_trk) o.mitigated = mitigate_tracked(o.mit_row);
      end
    endcase
    o.tracked_valid = trk_valid;
    o.tracked_row = trk_valid ? trk_row : '0;
    return o;
  endfunction

  // Result checker and output backpressure.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      quiet <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{alert: out_ch.alert, mitigated: out_ch.mitigated,
                mit_row: out_ch.mit_row, row_count: out_ch.row_count,
                tracked_valid: out_ch.tracked_valid, tracked_row: out_ch.tracked_row};
        if (pending_outcomes.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: alert=%0d mit=%0d victim=%0d count=%0d tv=%0d tr=%0d",
                     got.alert, got.mitigated, got.mit_row, got.row_count,
                     got.tracked_valid, got.tracked_row);
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("mismatch exp: alert=%0d mit=%0d victim=%0d count=%0d tv=%0d tr=%0d",
                       want.alert, want.mitigated, want.mit_row, want.row_count,
                       want.tracked_valid, want.tracked_row);
              $display("         got: alert=%0d mit=%0d victim=%0d count=%0d tv=%0d tr=%0d",
                       got.alert, got.mitigated, got.mit_row, got.row_count,
                       got.tracked_valid, got.tracked_row);
            end
            mismatches++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    wait (quiet >= QUIET_MAX);
    $display("Regression FAIL");
    $finish;
  end

  task automatic issue_event(mode_t m, logic [ROW_W-1:0] r, logic [OPEN_W-1:0] oc);
    int gap;
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(3, 1);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_outcomes.push_back(predict_event(m, r, oc));
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.row         <= r;
    in_ch.open_cycles <= oc;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_ALERT_TH:    th_alert = val;
      CFG_ENTRY_TH:    th_entry = val;
      CFG_EN_TRACKER:  en_trk = val[0];
      CFG_EN_CREDIT:   en_credit = val[0];
      CFG_CLR_ON_REF:  clr_ref = val[0];
      CFG_REF_PER_MIT: rpm = val & 16'h3FFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(logic [TH_W-1:0] a_th, logic [TH_W-1:0] e_th, bit trk,
                              bit credit, bit clr, int per_mit);
    settle();
    write_reg(CFG_ALERT_TH, a_th);
    write_reg(CFG_ENTRY_TH, e_th);
    write_reg(CFG_EN_TRACKER, CFG_DATA_W'(trk));
    write_reg(CFG_EN_CREDIT, CFG_DATA_W'(credit));
    write_reg(CFG_CLR_ON_REF, CFG_DATA_W'(clr));
    write_reg(CFG_REF_PER_MIT, CFG_DATA_W'(per_mit));
  endtask

  // Credit boundaries, tracker entry by activate, mitigation by refresh.
  task automatic test_credit_and_refresh();
    issue_event(MODE_PRE, 16'd100, 24'd0);
    issue_event(MODE_PRE, 16'd100, 24'd723);
    issue_event(MODE_PRE, 16'd100, 24'd724);
    issue_event(MODE_PRE, 16'd100, 24'd1443);
    issue_event(MODE_PRE, 16'd100, 24'd1444);
    issue_event(MODE_PRE, 16'd100, 24'hFFFFFF);
    issue_event(MODE_ACT, 16'd100, 24'd0);
    issue_event(MODE_REF, 16'd0, 24'd0);
    issue_event(MODE_ALERT, 16'd0, 24'd0);
  endtask

  // Edge rows, tracker replacement, disabled features, threshold extremes.
  task automatic test_edges();
    apply_config(16'd1, 16'd0, 1'b1, 1'b1, 1'b1, 1);
    issue_event(MODE_ACT, 16'd0, 24'd0);
    issue_event(MODE_ALERT, 16'hFFFF, 24'hFFFFFF);
    issue_event(MODE_ACT, 16'hFFFF, 24'd0);
    issue_event(MODE_ACT, 16'hFFFF, 24'd0);
    issue_event(MODE_ALERT, 16'd0, 24'd0);
    issue_event(MODE_ACT, 16'd1, 24'd0);
    issue_event(MODE_ACT, 16'd2, 24'd0);
    issue_event(MODE_ACT, 16'd2, 24'd0);
    issue_event(MODE_ALERT, 16'd0, 24'd0);
    issue_event(MODE_ALERT, 16'd0, 24'd0);
    apply_config(16'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 0);
    issue_event(MODE_PRE, 16'd10, 24'd5000);
    issue_event(MODE_ACT, 16'd10, 24'd0);
    issue_event(MODE_REF, 16'd0, 24'd0);
    apply_config(16'd64, 16'd32, 1'b0, 1'b0, 1'b0, 1);
    issue_event(MODE_ACT, 16'd20, 24'd0);
    issue_event(MODE_PRE, 16'd20, 24'hFFFFFF);
    issue_event(MODE_REF, 16'd0, 24'd0);
    issue_event(MODE_ALERT, 16'd0, 24'd0);
  endtask

  // Build one counter up by long precharges, then cross a raised alert threshold.
  task automatic test_heavy_row();
    int k;
    apply_config(16'd64, 16'd32, 1'b0, 1'b1, 1'b0, 1);
    for (k = 0; k < HEAVY_LEN; k++)
      issue_event(MODE_PRE, 16'd4000, 24'hFFFFFF);
    issue_event(MODE_ACT, 16'd4000, 24'd0);
    apply_config(16'd1200, 16'd0, 1'b1, 1'b1, 1'b0, 1);
    issue_event(MODE_ACT, 16'd4001, 24'd0);
    issue_event(MODE_ALERT, 16'd0, 24'd0);
    issue_event(MODE_ACT, 16'd4000, 24'd0);
    issue_event(MODE_ACT, 16'd4001, 24'd0);
    issue_event(MODE_ALERT, 16'd0, 24'd0);
  endtask

  task automatic pick_hot_rows();
    int base;
    base = $urandom_range(ROWS - 8);
    hot_rows[0] = ROW_W'($urandom_range(3));
    hot_rows[1] = ROW_W'(ROWS - 1 - $urandom_range(3));
    hot_rows[2] = ROW_W'((ref_group * PER_REF + $urandom_range(40)) % ROWS);
    hot_rows[3] = ROW_W'((ref_group * PER_REF + $urandom_range(40)) % ROWS);
    hot_rows[4] = ROW_W'(base);
    hot_rows[5] = ROW_W'(base + 1);
    hot_rows[6] = ROW_W'(base + 3);
    hot_rows[7] = ROW_W'($urandom);
  endtask

  task automatic test_random_phases();
    int p;
    int k;
    int sel;
    mode_t m;
    logic [ROW_W-1:0]  r;
    logic [OPEN_W-1:0] oc;
    for (p = 0; p < 6; p++) begin
      case (p)
        0: apply_config(16'd64, 16'd32, 1'b1, 1'b1, 1'b1, 1);
        1: apply_config(TH_W'($urandom_range(80, 1)), TH_W'($urandom_range(40)), 1'b1,
                        1'($urandom), 1'($urandom), $urandom_range(5, 2));
        2: apply_config(16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 0);
        3: apply_config(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 8192);
        4: apply_config(TH_W'($urandom), TH_W'($urandom), 1'b0, 1'($urandom),
                        1'($urandom), $urandom_range(8192));
        default: apply_config(TH_W'($urandom_range(120)), TH_W'($urandom_range(60)), 1'b1,
                              1'($urandom), 1'($urandom), $urandom_range(8192));
      endcase
      pick_hot_rows();
      for (k = 0; k < PHASE_LEN; k++) begin
        sel = $urandom_range(99);
        if (sel < 55) m = MODE_ACT;
        else if (sel < 75) m = MODE_PRE;
        else if (sel < 90) m = MODE_REF;
        else m = MODE_ALERT;
        if ($urandom_range(99) < 70) r = hot_rows[$urandom_range(7)];
        else r = ROW_W'($urandom);
        case ($urandom_range(3))
          0: oc = OPEN_W'($urandom_range(723));
          1: oc = OPEN_W'($urandom_range(1443, 724));
          2: oc = OPEN_W'($urandom);
          default: oc = ($urandom_range(1)) ? 24'hFFFFFF : 24'd0;
        endcase
        issue_event(m, r, oc);
      end
    end
  endtask

  // Long run of refreshes with no idling, mitigating every fourth group; then none.
  task automatic test_refresh_run();
    int k;
    apply_config(16'd64, 16'd0, 1'b1, 1'b1, 1'b1, 4);
    no_idle = 1'b1;
    for (k = 0; k < 200; k++) begin
      if (k % 16 == 0) issue_event(MODE_ACT, ROW_W'($urandom), 24'd0);
      issue_event(MODE_REF, ROW_W'($urandom), OPEN_W'($urandom));
    end
    issue_event(MODE_ALERT, 16'd0, 24'd0);
    no_idle = 1'b0;
    apply_config(16'd64, 16'd0, 1'b1, 1'b1, 1'b1, 0);
    for (k = 0; k < 20; k++) begin
      issue_event(MODE_ACT, ROW_W'($urandom_range(7)), 24'd0);
      issue_event(MODE_REF, 16'd0, 24'd0);
    end
    issue_event(MODE_ALERT, 16'd0, 24'd0);
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= '0;
    in_ch.row         <= '0;
    in_ch.open_cycles <= '0;
    trk_valid  = 1'b0;
    trk_row    = '0;
    ref_group  = 0;
    th_alert   = ALERT_TH_RST;
    th_entry   = ENTRY_TH_RST;
    en_trk     = 1'b1;
    en_credit  = 1'b1;
    clr_ref    = 1'b1;
    rpm        = RPM_RST;
    no_idle    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_credit_and_refresh();
    test_edges();
    test_heavy_row();
    test_random_phases();
    test_refresh_run();
    settle();
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/prac_pkg.sv
hdl/prac_if.sv
hdl/prac_ram.sv
hdl/prac_rem.sv
hdl/prac_rowhammer_tracker_top.sv
sim/tb_top.sv
